// ----- design/dpb_pkg.sv -----
// dpb_pkg: shared types and constants for the delayed pulse port bank
// holds field widths, stream packing sizes, opcodes, register indexes, reset values
// no dependencies
package dpb_pkg;

   // input item field widths
   localparam int unsigned INDEX_WIDTH   = 5;
   localparam int unsigned MS_WIDTH      = 16;
   localparam int unsigned CURRENT_WIDTH = 12;
   localparam int unsigned LEVEL_WIDTH   = 32;

   // stream packing, padded to whole bytes
   localparam int unsigned REQ_FIELDS_WIDTH = INDEX_WIDTH + 2 * MS_WIDTH + CURRENT_WIDTH;
   localparam int unsigned REQ_TDATA_WIDTH  = ((REQ_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int unsigned RSP_FIELDS_WIDTH = LEVEL_WIDTH + 2;
   localparam int unsigned RSP_TDATA_WIDTH  = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   // bit offsets inside req tdata
   localparam int unsigned REQ_DUR_LSB = INDEX_WIDTH;
   localparam int unsigned REQ_DLY_LSB = REQ_DUR_LSB + MS_WIDTH;
   localparam int unsigned REQ_CUR_LSB = REQ_DLY_LSB + MS_WIDTH;

   // configuration port
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PORT_MASK     = 2'd0,
      CSR_CURRENT_LIMIT = 2'd1,
      CSR_CHECK_ENABLE  = 2'd2
   } csr_index_type;

   localparam logic [LEVEL_WIDTH-1:0]   MASK_RESET   = '1;
   localparam logic [CURRENT_WIDTH-1:0] LIMIT_RESET  = 12'd2000;
   localparam logic                     CHECK_RESET  = 1'b1;

   // item kinds carried in req tuser
   typedef enum logic {
      OP_TICK   = 1'b0,
      OP_ENABLE = 1'b1
   } op_type;

   // per-port control from the bank
   typedef struct packed {
      logic tick;
      logic load;
      logic clear;
   } port_ctrl_type;

   // per-port status back to the bank
   typedef struct packed {
      logic is_on;
      logic turn_on;
      logic on_next;
   } port_status_type;

endpackage

// ----- design/dpb_port.sv -----
// dpb_port: one delayed one-shot timer (wait phase, on phase, down-counter)
// depends on dpb_pkg for the control and status structs
module dpb_port #(
   parameter int unsigned TIME_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dpb_pkg::port_ctrl_type   ctrl,
   input  logic [TIME_WIDTH-1:0]    load_delay,
   input  logic [TIME_WIDTH-1:0]    load_on_time,
   output dpb_pkg::port_status_type status
);
   import dpb_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_ON   = 2'd2
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] count_ff, count_in;
   logic [TIME_WIDTH-1:0] on_time_ff, on_time_in;
   logic [TIME_WIDTH-1:0] count_dec;
   logic                  expire;

   // saturating decrement, expiry when it reaches zero
   assign count_dec = (count_ff != '0) ? count_ff - TIME_WIDTH'(1) : '0;
   assign expire    = (count_dec == '0);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      on_time_in = on_time_ff;
      if (ctrl.clear) begin
         phase_in = PH_IDLE;
         count_in = '0;
      end else if (ctrl.load) begin
         phase_in   = PH_WAIT;
         count_in   = load_delay;
         on_time_in = load_on_time;
      end else if (ctrl.tick) begin
         case (phase_ff)
            PH_WAIT: begin
               if (expire) begin
                  count_in = on_time_ff;
                  phase_in = (on_time_ff == '0) ? PH_IDLE : PH_ON;
               end else begin
                  count_in = count_dec;
               end
            end
            PH_ON: begin
               count_in = count_dec;
               if (expire) phase_in = PH_IDLE;
            end
            default: ;
         endcase
      end
   end

   // status toward the bank
   assign status.is_on   = (phase_ff == PH_ON);
   assign status.turn_on = ctrl.tick && (phase_ff == PH_WAIT) && expire;
   assign status.on_next = (phase_in == PH_ON);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         on_time_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         on_time_ff <= on_time_in;
      end
   end

endmodule

// ----- design/delayed_pulse_port_bank.sv -----
// delayed_pulse_port_bank: top level, input register, port timer array, result register
// depends on dpb_pkg and dpb_port
//
// Usage:
//   req channel (req_tvalid/req_tready/req_tdata/req_tuser) carries one item per
//   tick or enable request; req_tuser selects the kind (0 tick, 1 enable).
//   rsp channel returns exactly one item per req item, in order: the drive level
//   of every port after that item, the accept flag and the overcurrent flag.
//   csr channel (always ready) writes the port mask (0), current limit (1), check
//   enable (2); the user must write it only while the bank is idle (unenforced).
// Path: an accepted req item passes the input register, then the result register.
// Throughput: one item per cycle unless the rsp side stalls; every port timer
//   decrements in parallel on a tick; the port state feeds the next item directly.
// Reset: all ports idle and low, registers to their reset values, both pipeline
//   stages empty.
// Stall: when rsp_tready is low the result register holds; the input register
//   still takes one more item, then req_tready drops until the result drains.
module delayed_pulse_port_bank #(
   parameter int unsigned PORTS           = 32,
   parameter int unsigned MIN_DELAY_TICKS = 1,
   parameter int unsigned TIME_WIDTH      = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req tdata: port_index[4:0], duration_ms[20:5], delay_ms[36:21], current_ma[48:37]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [dpb_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // req tuser: op
   input  logic                                  req_tuser,
   // rsp tdata: output_levels[31:0], request_accepted[32], overcurrent_trip[33]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [dpb_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dpb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dpb_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import dpb_pkg::*;

   localparam logic [32:0] TIME_MAX = (33'd1 << TIME_WIDTH) - 33'd1;

   // configuration registers
   logic [LEVEL_WIDTH-1:0]   port_mask_ff;
   logic [CURRENT_WIDTH-1:0] current_limit_ff;
   logic                     check_enable_ff;

   // input stage
   logic                     s1_valid_ff;
   op_type                   s1_op_ff;
   logic [INDEX_WIDTH-1:0]   s1_index_ff;
   logic [MS_WIDTH-1:0]      s1_duration_ff;
   logic [MS_WIDTH-1:0]      s1_delay_ff;
   logic [CURRENT_WIDTH-1:0] s1_current_ff;

   // result stage
   logic                       rsp_valid_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                    s1_advance;
   logic                    is_tick, is_enable, accept_req, any_turn_on, trip;
   logic [MS_WIDTH-1:0]     delay_raw;
   logic [TIME_WIDTH-1:0]   load_delay, load_on_time;
   logic [LEVEL_WIDTH-1:0]  on_vec, on_next_vec;
   logic [PORTS-1:0]        turn_on_vec;
   port_status_type         status [PORTS];

   // handshakes
   assign csr_ready  = 1'b1;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // request decode and checks
   assign is_tick    = s1_advance && (s1_op_ff == OP_TICK);
   assign is_enable  = s1_advance && (s1_op_ff == OP_ENABLE);
   assign accept_req = is_enable && (s1_duration_ff != '0)
                       && ({1'b0, s1_index_ff} < (INDEX_WIDTH + 1)'(PORTS))
                       && port_mask_ff[s1_index_ff] && !on_vec[s1_index_ff];

   // times saturate to the counter width, zero delay means the minimum
   assign delay_raw    = (s1_delay_ff != '0) ? s1_delay_ff : MS_WIDTH'(MIN_DELAY_TICKS);
   assign load_delay   = (33'(delay_raw) > TIME_MAX) ? TIME_MAX[TIME_WIDTH-1:0]
                                                     : TIME_WIDTH'(delay_raw);
   assign load_on_time = (33'(s1_duration_ff) > TIME_MAX) ? TIME_MAX[TIME_WIDTH-1:0]
                                                          : TIME_WIDTH'(s1_duration_ff);

   // overcurrent check when any port turns on this tick
   assign any_turn_on = |turn_on_vec;
   assign trip        = is_tick && any_turn_on && check_enable_ff
                        && (s1_current_ff > current_limit_ff);

   // port timer array
   for (genvar g = 0; g < LEVEL_WIDTH; g++) begin : g_port
      if (g < PORTS) begin : g_live
         port_ctrl_type ctrl;
         assign ctrl.tick  = is_tick;
         assign ctrl.load  = accept_req && (s1_index_ff == INDEX_WIDTH'(g));
         assign ctrl.clear = trip;

         dpb_port #(
            .TIME_WIDTH (TIME_WIDTH)
         ) u_port (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .load_delay   (load_delay),
            .load_on_time (load_on_time),
            .status       (status[g])
         );

         assign on_vec[g]      = status[g].is_on;
         assign on_next_vec[g] = status[g].on_next;
         assign turn_on_vec[g] = status[g].turn_on;
      end else begin : g_absent
         assign on_vec[g]      = 1'b0;
         assign on_next_vec[g] = 1'b0;
      end
   end

   // result item
   always_comb begin
      rsp_data_in                  = '0;
      rsp_data_in[LEVEL_WIDTH-1:0] = on_next_vec;
      rsp_data_in[LEVEL_WIDTH]     = accept_req;
      rsp_data_in[LEVEL_WIDTH+1]   = trip;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         port_mask_ff     <= MASK_RESET;
         current_limit_ff <= LIMIT_RESET;
         check_enable_ff  <= CHECK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PORT_MASK:     port_mask_ff     <= csr_data[LEVEL_WIDTH-1:0];
            CSR_CURRENT_LIMIT: current_limit_ff <= csr_data[CURRENT_WIDTH-1:0];
            CSR_CHECK_ENABLE:  check_enable_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_op_ff       <= op_type'(req_tuser);
         s1_index_ff    <= req_tdata[INDEX_WIDTH-1:0];
         s1_duration_ff <= req_tdata[REQ_DUR_LSB +: MS_WIDTH];
         s1_delay_ff    <= req_tdata[REQ_DLY_LSB +: MS_WIDTH];
         s1_current_ff  <= req_tdata[REQ_CUR_LSB +: CURRENT_WIDTH];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- design/dpb_checker.sv -----
// dpb_checker: port-level assertions for the delayed pulse port bank, with its bind
// depends on dpb_pkg; attaches to delayed_pulse_port_bank
module dpb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [dpb_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import dpb_pkg::*;

   // no result item right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp item valid right after reset");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed");

   // a trip leaves every port low
   a_trip_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[LEVEL_WIDTH+1] |-> rsp_tdata[LEVEL_WIDTH-1:0] == '0)
      else $error("overcurrent trip with ports still driven");

   // a result item is either a tick or a request, never both flags
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[LEVEL_WIDTH] && rsp_tdata[LEVEL_WIDTH+1]))
      else $error("accept and trip flags both set");

   // an item accepted while no rsp item is valid shows up after the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("accepted item did not reach the rsp channel");

endmodule

bind delayed_pulse_port_bank dpb_checker u_dpb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/tb.sv -----
// tb: self-checking bench for delayed_pulse_port_bank, directed script then random rounds
// keeps its own port timer model, checks every rsp item field by field in order
// depends on dpb_pkg and the delayed_pulse_port_bank rtl
module tb;
   import dpb_pkg::*;

   localparam int unsigned PORT_COUNT     = 32;
   localparam int unsigned STALL_LIMIT    = 5000;
   localparam int unsigned MISMATCH_SHOWN = 10;
   localparam int unsigned ROUND_ITEMS    = 200;
   localparam int unsigned SETTLE_CYCLES  = 10;
   localparam logic [MS_WIDTH-1:0] MIN_WAIT = 1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ARMED,
      PH_ACTIVE
   } port_phase_type;

   typedef enum logic {
      ROW_ITEM,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] levels;
      logic                   accepted;
      logic                   trip;
   } bank_report_type;

   typedef struct packed {
      row_kind_type              kind;
      op_type                    op;
      logic [INDEX_WIDTH-1:0]    idx;
      logic [MS_WIDTH-1:0]       dur;
      logic [MS_WIDTH-1:0]       dly;
      logic [CURRENT_WIDTH-1:0]  cur;
      csr_index_type             reg_sel;
      logic [CSR_DATA_WIDTH-1:0] reg_value;
      logic                      typed;
      bank_report_type           report;
   } script_row_type;

   // block inputs, all known from time zero
   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic [REQ_TDATA_WIDTH-1:0]  req_tdata  = '0;
   logic                        req_tuser  = 1'b0;
   logic                        rsp_tready = 1'b0;
   logic                        csr_valid  = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_data   = '0;
   logic                        req_tready;
   logic                        rsp_tvalid;
   logic [RSP_TDATA_WIDTH-1:0]  rsp_tdata;
   logic                        csr_ready;

   // model of the bank: configuration and per-port timers
   logic [LEVEL_WIDTH-1:0]   model_mask;
   logic [CURRENT_WIDTH-1:0] model_limit;
   logic                     model_check;
   port_phase_type           port_state [PORT_COUNT];
   logic [MS_WIDTH-1:0]      port_count [PORT_COUNT];
   logic [MS_WIDTH-1:0]      port_width [PORT_COUNT];
   logic [LEVEL_WIDTH-1:0]   bank_levels;

   bank_report_type pending_reports[$];
   script_row_type  script[$];
   int unsigned     mismatch_count = 0;
   int unsigned     quiet_cycles   = 0;
   logic            steady         = 1'b0;

   // expectation typed into the script for the item now on the bus
   logic            drv_typed        = 1'b0;
   bank_report_type drv_typed_report = '0;

   delayed_pulse_port_bank dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // a break roughly 15 times in 100, none during a steady stretch
   function automatic logic take_break();
      return !steady && ($urandom_range(0, 99) < 15);
   endfunction

   // timer values: mostly short so ports cycle often, sometimes zero or full range
   function automatic logic [MS_WIDTH-1:0] pick_time();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         return '0;
      else if (roll < 92)
         return MS_WIDTH'($urandom_range(1, 8));
      else
         return MS_WIDTH'($urandom_range(0, 65535));
   endfunction

   // apply one item to the model, return the levels and flags it should produce
   function automatic bank_report_type step_port_bank(
      input op_type                   op,
      input logic [INDEX_WIDTH-1:0]   idx,
      input logic [MS_WIDTH-1:0]      dur,
      input logic [MS_WIDTH-1:0]      dly,
      input logic [CURRENT_WIDTH-1:0] cur
   );
      bank_report_type rep;
      logic            fired;
      int              i;
      rep   = '0;
      fired = 1'b0;
      if (op == OP_ENABLE) begin
         // a port that is on refuses, a waiting port restarts its wait
         if (dur != '0 && model_mask[idx] && port_state[idx] != PH_ACTIVE) begin
            port_width[idx] = dur;
            port_count[idx] = (dly != '0) ? dly : MIN_WAIT;
            port_state[idx] = PH_ARMED;
            rep.accepted    = 1'b1;
         end
      end else begin
         for (i = 0; i < PORT_COUNT; i++) begin
            if (port_state[i] == PH_ARMED) begin
               if (port_count[i] != '0)
                  port_count[i]--;
               if (port_count[i] == '0) begin
                  port_state[i]  = PH_ACTIVE;
                  port_count[i]  = port_width[i];
                  bank_levels[i] = 1'b1;
                  fired          = 1'b1;
                  if (port_count[i] == '0) begin
                     port_state[i]  = PH_IDLE;
                     bank_levels[i] = 1'b0;
                  end
               end
            end else if (port_state[i] == PH_ACTIVE) begin
               if (port_count[i] != '0)
                  port_count[i]--;
               if (port_count[i] == '0) begin
                  port_state[i]  = PH_IDLE;
                  bank_levels[i] = 1'b0;
               end
            end
         end
         // overcurrent on turn-on drops every port, new ones included
         if (fired && model_check && cur > model_limit) begin
            for (i = 0; i < PORT_COUNT; i++) begin
               port_state[i] = PH_IDLE;
               port_count[i] = '0;
            end
            bank_levels = '0;
            rep.trip    = 1'b1;
         end
      end
      rep.levels = bank_levels;
      return rep;
   endfunction

   task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN)
         $display("mismatch %0s: expected %h, got %h", what, want, got);
   endtask

   task automatic add_row(
      input op_type                   op,
      input logic [INDEX_WIDTH-1:0]   idx,
      input logic [MS_WIDTH-1:0]      dur,
      input logic [MS_WIDTH-1:0]      dly,
      input logic [CURRENT_WIDTH-1:0] cur,
      input logic                     typed,
      input logic [LEVEL_WIDTH-1:0]   levels,
      input logic                     accepted,
      input logic                     trip
   );
      script_row_type row;
      row                 = '0;
      row.kind            = ROW_ITEM;
      row.op              = op;
      row.idx             = idx;
      row.dur             = dur;
      row.dly             = dly;
      row.cur             = cur;
      row.typed           = typed;
      row.report.levels   = levels;
      row.report.accepted = accepted;
      row.report.trip     = trip;
      script.push_back(row);
   endtask

   task automatic add_csr(input csr_index_type sel, input logic [CSR_DATA_WIDTH-1:0] value);
      script_row_type row;
      row           = '0;
      row.kind      = ROW_CSR;
      row.reg_sel   = sel;
      row.reg_value = value;
      script.push_back(row);
   endtask

   // present one item at the falling edge and hold it until taken
   task automatic drive_item(input script_row_type row);
      logic [REQ_TDATA_WIDTH-1:0] word;
      while (take_break()) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      word = '0;
      word[0 +: INDEX_WIDTH]             = row.idx;
      word[REQ_DUR_LSB +: MS_WIDTH]      = row.dur;
      word[REQ_DLY_LSB +: MS_WIDTH]      = row.dly;
      word[REQ_CUR_LSB +: CURRENT_WIDTH] = row.cur;
      req_tdata        = word;
      req_tuser        = row.op;
      drv_typed        = row.typed;
      drv_typed_report = row.report;
      req_tvalid       = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic finish_outstanding();
      req_tvalid = 1'b0;
      while (pending_reports.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type sel, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid = 1'b1;
      csr_index = sel;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // result side readiness, changed at the falling edge
   always @(negedge clock) begin
      rsp_tready = !take_break();
   end

   // sample all three channels at the rising edge: check results, predict items, track writes
   always @(posedge clock) begin : monitor
      bank_report_type got;
      bank_report_type want;
      logic            moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            moved        = 1'b1;
            got.levels   = rsp_tdata[LEVEL_WIDTH-1:0];
            got.accepted = rsp_tdata[LEVEL_WIDTH];
            got.trip     = rsp_tdata[LEVEL_WIDTH+1];
            if (pending_reports.size() == 0) begin
               flag("result with nothing expected", '0, got.levels);
            end else begin
               want = pending_reports.pop_front();
               if (got.levels !== want.levels)
                  flag("output_levels", want.levels, got.levels);
               if (got.accepted !== want.accepted)
                  flag("request_accepted", 32'(want.accepted), 32'(got.accepted));
               if (got.trip !== want.trip)
                  flag("overcurrent_trip", 32'(want.trip), 32'(got.trip));
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            want  = step_port_bank(op_type'(req_tuser), req_tdata[0 +: INDEX_WIDTH],
                                   req_tdata[REQ_DUR_LSB +: MS_WIDTH],
                                   req_tdata[REQ_DLY_LSB +: MS_WIDTH],
                                   req_tdata[REQ_CUR_LSB +: CURRENT_WIDTH]);
            if (drv_typed)
               want = drv_typed_report;
            pending_reports.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index_type'(csr_index))
               CSR_PORT_MASK:     model_mask  = csr_data[LEVEL_WIDTH-1:0];
               CSR_CURRENT_LIMIT: model_limit = csr_data[CURRENT_WIDTH-1:0];
               CSR_CHECK_ENABLE:  model_check = csr_data[0];
               default: ;
            endcase
         end
      end
      // watchdog on cycles with no handshake at all
      if (moved)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("** delayed_pulse_port_bank: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      script_row_type row;
      int unsigned    round;
      int unsigned    n;
      int             i;

      // model state after reset
      model_mask  = MASK_RESET;
      model_limit = LIMIT_RESET;
      model_check = CHECK_RESET;
      bank_levels = '0;
      for (i = 0; i < PORT_COUNT; i++) begin
         port_state[i] = PH_IDLE;
         port_count[i] = '0;
         port_width[i] = '0;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed script, reset settings: mask all ones, limit 2000, check on
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'h000, 1, 32'h0000_0000, 0, 0);
      // zero duration is refused
      add_row(OP_ENABLE, 0, 16'h0000, 16'h0005, 12'h000, 1, 32'h0000_0000, 0, 0);
      // widest fields, port 31 starts a very long wait
      add_row(OP_ENABLE, 31, 16'hffff, 16'hffff, 12'hfff, 1, 32'h0000_0000, 1, 0);
      // zero delay means the minimum wait
      add_row(OP_ENABLE, 5, 16'h0001, 16'h0000, 12'h000, 1, 32'h0000_0000, 1, 0);
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'h000, 1, 32'h0000_0020, 0, 0);
      // port already on is refused
      add_row(OP_ENABLE, 5, 16'h0003, 16'h0003, 12'h000, 1, 32'h0000_0020, 0, 0);
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'h000, 1, 32'h0000_0000, 0, 0);
      // second request during the wait restarts it
      add_row(OP_ENABLE, 7, 16'h0002, 16'h0001, 12'h000, 1, 32'h0000_0000, 1, 0);
      add_row(OP_ENABLE, 7, 16'h0004, 16'h0002, 12'h000, 1, 32'h0000_0000, 1, 0);
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'd2000, 1, 32'h0000_0000, 0, 0);
      // just over the limit at turn-on clears everything, port 31 too
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'd2001, 1, 32'h0000_0000, 0, 1);
      add_row(OP_ENABLE, 9, 16'h0003, 16'h0001, 12'h000, 1, 32'h0000_0000, 1, 0);
      // current equal to the limit does not trip
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'd2000, 1, 32'h0000_0200, 0, 0);
      // mask cleared while port 9 is on: it keeps running, new requests refused
      add_csr(CSR_PORT_MASK, 32'h0000_0000);
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'h000, 1, 32'h0000_0200, 0, 0);
      add_row(OP_ENABLE, 1, 16'h0005, 16'h0001, 12'h000, 1, 32'h0000_0200, 0, 0);
      add_csr(CSR_CHECK_ENABLE, 32'h0000_0000);
      add_csr(CSR_CURRENT_LIMIT, 32'h0000_0000);
      add_csr(CSR_PORT_MASK, 32'haaaa_aaaa);
      add_row(OP_ENABLE, 0, 16'h0001, 16'h0001, 12'h000, 0, '0, 0, 0);
      add_row(OP_ENABLE, 3, 16'h0001, 16'h0001, 12'h000, 0, '0, 0, 0);
      // check off: full current passes
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'hfff, 0, '0, 0, 0);
      add_csr(CSR_CHECK_ENABLE, 32'h0000_0001);
      add_row(OP_ENABLE, 11, 16'h0001, 16'h0001, 12'h000, 0, '0, 0, 0);
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'h001, 0, '0, 0, 0);
      add_csr(CSR_CURRENT_LIMIT, 32'h0000_0fff);
      add_csr(CSR_PORT_MASK, 32'hffff_ffff);
      add_row(OP_ENABLE, 2, 16'h0002, 16'h0001, 12'h000, 0, '0, 0, 0);
      // top current equals top limit: no trip
      add_row(OP_TICK,   0, 16'h0000, 16'h0000, 12'hfff, 0, '0, 0, 0);

      for (n = 0; n < script.size(); n++) begin
         row = script[n];
         if (row.kind == ROW_CSR) begin
            finish_outstanding();
            csr_write(row.reg_sel, row.reg_value);
         end else begin
            drive_item(row);
         end
      end

      // random rounds, each under its own register setting
      for (round = 0; round < 5; round++) begin
         finish_outstanding();
         case (round)
            0: begin
               csr_write(CSR_PORT_MASK, $urandom | $urandom);
               csr_write(CSR_CURRENT_LIMIT, $urandom_range(1500, 2500));
               csr_write(CSR_CHECK_ENABLE, 32'd1);
            end
            1: begin
               csr_write(CSR_PORT_MASK, $urandom);
               csr_write(CSR_CURRENT_LIMIT, 32'd0);
               csr_write(CSR_CHECK_ENABLE, 32'd1);
            end
            2: begin
               csr_write(CSR_PORT_MASK, 32'hffff_ffff);
               csr_write(CSR_CURRENT_LIMIT, 32'd4095);
               csr_write(CSR_CHECK_ENABLE, 32'd1);
            end
            3: begin
               csr_write(CSR_PORT_MASK, $urandom | $urandom);
               csr_write(CSR_CURRENT_LIMIT, $urandom_range(0, 4095));
               csr_write(CSR_CHECK_ENABLE, 32'd0);
            end
            default: begin
               csr_write(CSR_PORT_MASK, 32'hffff_ffff);
               csr_write(CSR_CURRENT_LIMIT, $urandom_range(0, 4095));
               csr_write(CSR_CHECK_ENABLE, 32'd1);
            end
         endcase
         // one round runs with no idling on either side
         steady = (round == 2);
         for (n = 0; n < ROUND_ITEMS; n++) begin
            row      = '0;
            row.kind = ROW_ITEM;
            if ($urandom_range(0, 99) < 30) begin
               row.op  = OP_ENABLE;
               row.idx = INDEX_WIDTH'($urandom_range(0, PORT_COUNT - 1));
               row.dur = pick_time();
               row.dly = pick_time();
            end else begin
               row.op = OP_TICK;
            end
            // mostly at or under the limit so ports live a while, sometimes anything
            if ($urandom_range(0, 3) == 0)
               row.cur = CURRENT_WIDTH'($urandom_range(0, 4095));
            else
               row.cur = CURRENT_WIDTH'($urandom_range(0, model_limit));
            drive_item(row);
         end
      end

      steady = 1'b0;
      finish_outstanding();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("** delayed_pulse_port_bank: PASSED **");
      else
         $display("** delayed_pulse_port_bank: FAILED **");
      $finish;
   end

endmodule
